// ----- design/tpd_pkg.sv -----
// Package of the Thumb instruction predecoder: kinds, field widths and the result record.
`default_nettype none

package tpd_pkg;

	// Widths of the item fields.
	localparam int unsigned WordW   = 32;
	localparam int unsigned RegW    = 4;
	localparam int unsigned ListW   = 9;
	localparam int unsigned CondW   = 4;
	localparam int unsigned LenW    = 3;
	localparam int unsigned InDataW = 64;
	localparam int unsigned OutDataW = 104;

	// Instruction kinds reported on the result side.
	typedef enum logic [4:0] {
		KIND_UNKNOWN = 5'd0,
		KIND_BX      = 5'd1,
		KIND_SUBSP   = 5'd2,
		KIND_ORRW    = 5'd3,
		KIND_MOVW    = 5'd4,
		KIND_BICW    = 5'd5,
		KIND_CMP     = 5'd6,
		KIND_SUBIMM  = 5'd7,
		KIND_SUBREG  = 5'd8,
		KIND_POP     = 5'd9,
		KIND_PUSH    = 5'd10,
		KIND_LDRREG  = 5'd11,
		KIND_STRIMM  = 5'd12,
		KIND_LDRIMM  = 5'd13,
		KIND_LDRLIT  = 5'd14,
		KIND_MOVS    = 5'd15,
		KIND_BL      = 5'd16,
		KIND_BCOND   = 5'd17
	} kind_t;

	// Lowest condition code that the conditional branch pattern does not accept.
	localparam logic [CondW-1:0] CondAlways = 4'd14;

	// Implicit register numbers.
	localparam logic [RegW-1:0] RegSp = 4'd13;
	localparam logic [RegW-1:0] RegPc = 4'd15;

	// Instruction lengths in bytes.
	localparam logic [LenW-1:0] LenNarrow = 3'd2;
	localparam logic [LenW-1:0] LenWide   = 3'd4;

	// One decoded instruction.
	typedef struct packed {
		kind_t              kind;
		logic [RegW-1:0]    reg_dest;
		logic [RegW-1:0]    reg_first;
		logic [RegW-1:0]    reg_second;
		logic [WordW-1:0]   imm_value;
		logic [ListW-1:0]   reg_list;
		logic [CondW-1:0]   cond_code;
		logic [LenW-1:0]    length_bytes;
		logic [WordW-1:0]   branch_target;
	} result_t;

	// Thumb modified-immediate expansion of i:imm3:imm8.
	function automatic logic [WordW-1:0] expand_mod_imm(input logic [11:0] imm12);
		logic [7:0]        b;
		logic [WordW-1:0]  v;
		logic [2*WordW-1:0] rot;
		logic [4:0]        sh;
		b   = imm12[7:0];
		v   = {24'd0, 1'b1, imm12[6:0]};
		sh  = imm12[11:7];
		rot = {v, v} >> sh;
		if (imm12[11:10] == 2'b00) begin
			case (imm12[9:8])
				2'd0:    expand_mod_imm = {24'd0, b};
				2'd1:    expand_mod_imm = {8'd0, b, 8'd0, b};
				2'd2:    expand_mod_imm = {b, 8'd0, b, 8'd0};
				default: expand_mod_imm = {b, b, b, b};
			endcase
		end else begin
			expand_mod_imm = rot[WordW-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- design/thumb_instruction_predecoder.sv -----
// Top level of the Thumb instruction predecoder: input register, decode logic and result register.
`default_nettype none

// Decodes one 32-bit Thumb fetch word and its address into an instruction kind, register
// fields, immediate, register list, condition, length and branch target. Each item passes
// an input register and a result register with one level of decode logic between them, and
// one item is taken in every cycle while the result side keeps up. The input side stays
// ready while the input register is empty or can move on, so a stalled result holds
// without losing the item behind it.
module thumb_instruction_predecoder
	import tpd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// pc_value [31:0], instr_word [63:32]
	input  wire logic [InDataW-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// kind [4:0], reg_dest [8:5], reg_first [12:9], reg_second [16:13], imm_value [48:17],
	// reg_list [57:49], cond_code [61:58], length_bytes [64:62], branch_target [96:65],
	// zero [103:97]
	output logic [OutDataW-1:0]      m_tdata
);

	logic             valid_s1;
	logic             valid_s2;
	logic [WordW-1:0] pc_s1;
	logic [WordW-1:0] word_s1;
	result_t          res_d;
	result_t          res_s2;
	logic             adv_s2;
	logic             accept;

	// Handshake: the result register frees when empty or taken, the input register follows.
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign accept   = s_tvalid && s_tready;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pc_s1   <= s_tdata[31:0];
			word_s1 <= s_tdata[63:32];
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	// First-match decode of the registered word.
	always_comb begin
		logic [15:0]      h0;
		logic [15:0]      h1;
		logic [WordW-1:0] imm_b;
		logic             s;
		h0    = word_s1[15:0];
		h1    = word_s1[31:16];
		s     = h0[10];
		imm_b = '0;
		res_d = '0;
		res_d.kind         = KIND_UNKNOWN;
		res_d.length_bytes = LenNarrow;
		if ((h0 & 16'hFF87) == 16'h4700) begin
			res_d.kind      = KIND_BX;
			res_d.reg_first = h0[6:3];
		end else if ((h0 & 16'hFF80) == 16'hB080) begin
			res_d.kind      = KIND_SUBSP;
			res_d.reg_dest  = RegSp;
			res_d.reg_first = RegSp;
			res_d.imm_value = {23'd0, h0[6:0], 2'b00};
		end else if ((h0 & 16'hFBE0) == 16'hF040 || (h0 & 16'hFBE0) == 16'hF020) begin
			res_d.length_bytes = LenWide;
			if (!h1[15]) begin
				res_d.reg_dest  = h1[11:8];
				res_d.imm_value = expand_mod_imm({h0[10], h1[14:12], h1[7:0]});
				if ((h0 & 16'hFBE0) == 16'hF020) begin
					res_d.kind      = KIND_BICW;
					res_d.reg_first = h0[3:0];
				end else if (h0[3:0] == RegPc) begin
					res_d.kind = KIND_MOVW;
				end else begin
					res_d.kind      = KIND_ORRW;
					res_d.reg_first = h0[3:0];
				end
			end
		end else if ((h0 & 16'hFFC0) == 16'h4280) begin
			res_d.kind       = KIND_CMP;
			res_d.reg_first  = {1'b0, h0[2:0]};
			res_d.reg_second = {1'b0, h0[5:3]};
		end else if ((h0 & 16'hFE00) == 16'h1E00) begin
			res_d.kind      = KIND_SUBIMM;
			res_d.reg_dest  = {1'b0, h0[2:0]};
			res_d.reg_first = {1'b0, h0[5:3]};
			res_d.imm_value = {29'd0, h0[8:6]};
		end else if ((h0 & 16'hFE00) == 16'h1A00) begin
			res_d.kind       = KIND_SUBREG;
			res_d.reg_dest   = {1'b0, h0[2:0]};
			res_d.reg_first  = {1'b0, h0[5:3]};
			res_d.reg_second = {1'b0, h0[8:6]};
		end else if ((h0 & 16'hFE00) == 16'hBC00) begin
			res_d.kind     = KIND_POP;
			res_d.reg_list = h0[8:0];
		end else if ((h0 & 16'hFE00) == 16'hB400) begin
			res_d.kind     = KIND_PUSH;
			res_d.reg_list = h0[8:0];
		end else if ((h0 & 16'hFE00) == 16'h5800) begin
			res_d.kind       = KIND_LDRREG;
			res_d.reg_dest   = {1'b0, h0[2:0]};
			res_d.reg_first  = {1'b0, h0[5:3]};
			res_d.reg_second = {1'b0, h0[8:6]};
		end else if ((h0 & 16'hF800) == 16'h6000) begin
			res_d.kind      = KIND_STRIMM;
			res_d.reg_dest  = {1'b0, h0[2:0]};
			res_d.reg_first = {1'b0, h0[5:3]};
			res_d.imm_value = {25'd0, h0[10:6], 2'b00};
		end else if ((h0 & 16'hF800) == 16'h6800) begin
			res_d.kind      = KIND_LDRIMM;
			res_d.reg_dest  = {1'b0, h0[2:0]};
			res_d.reg_first = {1'b0, h0[5:3]};
			res_d.imm_value = {25'd0, h0[10:6], 2'b00};
		end else if ((h0 & 16'hF800) == 16'h4800) begin
			res_d.kind      = KIND_LDRLIT;
			res_d.reg_dest  = {1'b0, h0[10:8]};
			res_d.reg_first = RegPc;
			res_d.imm_value = {22'd0, h0[7:0], 2'b00};
		end else if ((h0 & 16'hF800) == 16'h2000) begin
			res_d.kind      = KIND_MOVS;
			res_d.reg_dest  = {1'b0, h0[10:8]};
			res_d.imm_value = {24'd0, h0[7:0]};
		end else if ((h0 & 16'hF800) == 16'hF000) begin
			// Long branch with link; the exchanging form is recognised only for its length.
			if ((h1 & 16'hD000) == 16'hD000) begin
				imm_b = {{8{s}}, h1[13] ^ s ^ 1'b1, h1[11] ^ s ^ 1'b1,
					h0[9:0], h1[10:0], 1'b0};
				res_d.kind          = KIND_BL;
				res_d.length_bytes  = LenWide;
				res_d.imm_value     = imm_b;
				res_d.branch_target = pc_s1 + 32'd4 + imm_b;
			end else if ((h1 & 16'hD000) == 16'hC000) begin
				res_d.length_bytes = LenWide;
			end
		end else if ((h0 & 16'hF000) == 16'hD000) begin
			// Conditional branch; the always and never conditions are not decoded here.
			if (h0[11:8] < CondAlways) begin
				imm_b = {{23{h0[7]}}, h0[7:0], 1'b0};
				res_d.kind          = KIND_BCOND;
				res_d.cond_code     = h0[11:8];
				res_d.imm_value     = imm_b;
				res_d.branch_target = pc_s1 + 32'd4 + imm_b;
			end
		end
	end

	// Result port.
	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.branch_target, res_s2.length_bytes, res_s2.cond_code,
		res_s2.reg_list, res_s2.imm_value, res_s2.reg_second, res_s2.reg_first,
		res_s2.reg_dest, res_s2.kind};

	// An accepted item always lands in the input register.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach the input register");

	// A held result with the input register full must keep the input side stalled.
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input accepted while both stages are blocked");

	// Length is two or four, and a long branch is always four bytes.
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.length_bytes == LenNarrow || res_s2.length_bytes == LenWide)
		&& (res_s2.kind != KIND_BL || res_s2.length_bytes == LenWide)))
		else $error("bad instruction length");

	// Unknown instructions carry no immediate, list, condition or target.
	a_unknown_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == KIND_UNKNOWN) |-> (res_s2.imm_value == '0
		&& res_s2.reg_list == '0 && res_s2.cond_code == '0 && res_s2.branch_target == '0))
		else $error("unknown instruction carries field data");

endmodule

`default_nettype wire
